>>> hdl/fcm_pkg.sv
// Shared constants and types for the allocation table manager.
package fcm_pkg;

	// Default table size
	localparam int BLOCK_COUNT_DEF = 2048;

	// Field widths
	localparam int OP_W    = 3;
	localparam int BLK_W   = 11;
	localparam int ENTRY_W = 16;
	localparam int STAT_W  = 2;

	// Entry codes
	localparam logic [ENTRY_W-1:0] ENT_FREE = 16'h0000;
	localparam logic [ENTRY_W-1:0] ENT_RSVD = 16'h7ffe;
	localparam logic [ENTRY_W-1:0] ENT_END  = 16'hffff;

	// Reserved blocks at the bottom of the table, then the root end block
	localparam int RSVD_COUNT = 5;
	localparam int ROOT_BLOCK = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_FORMAT = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
	localparam logic [OP_W-1:0] OP_KEEP   = 3'd3;
	localparam logic [OP_W-1:0] OP_EXTEND = 3'd4;
	localparam logic [OP_W-1:0] OP_READ   = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;
	localparam logic [STAT_W-1:0] ST_LONG = 2'd3;

	// Classification of one table entry
	typedef struct packed {
		logic is_end;
		logic is_free;
		logic is_bad;
	} entry_class_t;

endpackage

>>> hdl/fcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/fcm_entry_eval.sv
// Shared compare unit: classifies one table entry read from the RAM.
module fcm_entry_eval #(
	parameter int BLOCK_COUNT = fcm_pkg::BLOCK_COUNT_DEF
) (
	input  logic [fcm_pkg::ENTRY_W-1:0] entry,
	output fcm_pkg::entry_class_t       cls
);
	import fcm_pkg::*;

	logic out_of_range;

	// Flag a link that points past the table
	assign out_of_range = {16'd0, entry} >= 32'(BLOCK_COUNT);

	// Decode end, free and broken-link cases
	always_comb begin
		cls.is_end  = (entry == ENT_END);
		cls.is_free = (entry == ENT_FREE);
		cls.is_bad  = (entry == ENT_FREE) || (entry == ENT_RSVD) ||
			(out_of_range && (entry != ENT_END));
	end

endmodule

>>> hdl/fat_chain_manager.sv
// Top level: allocation table sequencer around one table RAM and the entry compare unit.
//
//   channel  | ports                           | handshake
//   ---------+---------------------------------+-------------------------------
//   command  | op, start_block                 | taken when start & !busy
//   result   | status, block, link, is_end     | one-cycle done strobe
//
// Every table access is an address state followed by a state that uses the registered data.
// A chain walk makes one access per chain entry, a free pass another access per entry, and a
// free-entry search one access per entry visited from the lowest-free hint upward.
// Format and the clearing pass after reset sweep the RAM at one entry a cycle;
// busy stays high during the sweep after reset.
// The receiver cannot stall: each result shows for one cycle with done high.
module fat_chain_manager #(
	parameter int BLOCK_COUNT = fcm_pkg::BLOCK_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [fcm_pkg::OP_W-1:0]   op,
	input  logic [fcm_pkg::BLK_W-1:0]  start_block,
	output logic                       done,
	output logic [fcm_pkg::STAT_W-1:0] status,
	output logic [fcm_pkg::BLK_W-1:0]  block,
	output logic [fcm_pkg::ENTRY_W-1:0] link,
	output logic                       is_end
);
	import fcm_pkg::*;

	localparam int IW = $clog2(BLOCK_COUNT);
	localparam logic [IW:0] N_W    = (IW+1)'(BLOCK_COUNT);
	localparam logic [IW:0] HINT_0 = (IW+1)'(ROOT_BLOCK + 1);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_WALK_RD,
		S_WALK_EV,
		S_FREE_RD,
		S_FREE_EV,
		S_SCAN_RD,
		S_SCAN_EV,
		S_LINK,
		S_READ_RD,
		S_READ_EV
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [IW-1:0]       start_q;
	logic [IW-1:0]       cur_q;
	logic [IW-1:0]       last_q;
	logic [IW:0]         cnt_q;
	logic [IW:0]         hint_q;
	logic                fmt_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [BLK_W-1:0]    block_q;
	logic [ENTRY_W-1:0]  link_q;
	logic                is_end_q;

	logic                 we;
	logic [IW-1:0]        waddr;
	logic [ENTRY_W-1:0]   wdata;
	logic [IW-1:0]        raddr;
	logic [ENTRY_W-1:0]   rdata;
	entry_class_t         cls;
	logic                 start_bad;
	logic                 cur_below_hint;
	logic [IW-1:0]        next_idx;

	// Table storage
	fcm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (BLOCK_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Classify the entry just read
	fcm_entry_eval #(
		.BLOCK_COUNT (BLOCK_COUNT)
	) u_eval (
		.entry (rdata),
		.cls   (cls)
	);

	assign start_bad      = 32'(start_block) >= 32'(BLOCK_COUNT);
	assign cur_below_hint = {1'b0, cur_q} < hint_q;
	assign next_idx       = IW'(rdata);

	// Drive the RAM ports from the current state
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = ENT_FREE;
		raddr = cur_q;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = cnt_q[IW-1:0];
				if (cnt_q < (IW+1)'(RSVD_COUNT)) begin
					wdata = ENT_RSVD;
				end else if (cnt_q == (IW+1)'(ROOT_BLOCK)) begin
					wdata = ENT_END;
				end else begin
					wdata = ENT_FREE;
				end
			end
			S_SCAN_RD: begin
				raddr = cnt_q[IW-1:0];
			end
			S_FREE_EV: begin
				we = !cls.is_end || (op_q == OP_FREE);
			end
			S_SCAN_EV: begin
				we    = cls.is_free;
				waddr = cnt_q[IW-1:0];
				wdata = ENT_END;
			end
			S_LINK: begin
				we    = 1'b1;
				waddr = last_q;
				wdata = ENTRY_W'(cur_q);
			end
			default: begin
			end
		endcase
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			op_q     <= OP_FORMAT;
			start_q  <= '0;
			cur_q    <= '0;
			last_q   <= '0;
			cnt_q    <= '0;
			hint_q   <= HINT_0;
			fmt_q    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			block_q  <= '0;
			link_q   <= '0;
			is_end_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				// Sweep the table to its formatted contents
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == N_W - 1'b1) begin
						hint_q  <= HINT_0;
						state_q <= S_IDLE;
						if (fmt_q) begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							block_q  <= '0;
							link_q   <= '0;
							is_end_q <= 1'b0;
						end
					end
				end
				// Take a command word
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						start_q <= IW'(start_block);
						cur_q   <= IW'(start_block);
						cnt_q   <= '0;
						if (op == OP_FORMAT) begin
							fmt_q   <= 1'b1;
							state_q <= S_INIT;
						end else if (op == OP_ALLOC) begin
							cnt_q   <= hint_q;
							state_q <= S_SCAN_RD;
						end else if ((op == OP_FREE || op == OP_KEEP || op == OP_EXTEND ||
							op == OP_READ) && !start_bad) begin
							state_q <= (op == OP_READ) ? S_READ_RD : S_WALK_RD;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_BAD;
							block_q  <= '0;
							link_q   <= '0;
							is_end_q <= 1'b0;
						end
					end
				end
				// Check the chain before touching it
				S_WALK_RD: begin
					state_q <= S_WALK_EV;
				end
				S_WALK_EV: begin
					if (cls.is_end) begin
						last_q <= cur_q;
						if (op_q == OP_EXTEND) begin
							cnt_q   <= hint_q;
							state_q <= S_SCAN_RD;
						end else begin
							cur_q   <= start_q;
							state_q <= S_FREE_RD;
						end
					end else if (cls.is_bad || (cnt_q + 1'b1 == N_W)) begin
						done_q   <= 1'b1;
						status_q <= cls.is_bad ? ST_BAD : ST_LONG;
						block_q  <= '0;
						link_q   <= '0;
						is_end_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						cur_q   <= next_idx;
						state_q <= S_WALK_RD;
					end
				end
				// Release chain entries, lowering the free hint
				S_FREE_RD: begin
					state_q <= S_FREE_EV;
				end
				S_FREE_EV: begin
					if ((!cls.is_end || op_q == OP_FREE) && cur_below_hint) begin
						hint_q <= {1'b0, cur_q};
					end
					if (cls.is_end) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						block_q  <= (op_q == OP_KEEP) ? BLK_W'(cur_q) : '0;
						link_q   <= '0;
						is_end_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= next_idx;
						state_q <= S_FREE_RD;
					end
				end
				// Search upward from the hint for a free entry
				S_SCAN_RD: begin
					if (cnt_q == N_W) begin
						hint_q   <= N_W;
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						block_q  <= '0;
						link_q   <= '0;
						is_end_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					if (cls.is_free) begin
						hint_q <= cnt_q + 1'b1;
						cur_q  <= cnt_q[IW-1:0];
						if (op_q == OP_EXTEND) begin
							state_q <= S_LINK;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							block_q  <= BLK_W'(cnt_q[IW-1:0]);
							link_q   <= '0;
							is_end_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				// Point the old end at the new block
				S_LINK: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					block_q  <= BLK_W'(cur_q);
					link_q   <= '0;
					is_end_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				// Return one raw entry
				S_READ_RD: begin
					state_q <= S_READ_EV;
				end
				S_READ_EV: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					block_q  <= '0;
					link_q   <= rdata;
					is_end_q <= cls.is_end;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign block  = block_q;
	assign link   = link_q;
	assign is_end = is_end_q;

endmodule

>>> tb/fcm_checker.sv
`timescale 1ns / 100ps
// Checker for the allocation table manager: shadow table, expected result words and compare.
module fcm_checker #(
	parameter int BLOCK_COUNT = fcm_pkg::BLOCK_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [fcm_pkg::OP_W-1:0]    op,
	input  logic [fcm_pkg::BLK_W-1:0]   start_block,
	input  logic                        done,
	input  logic [fcm_pkg::STAT_W-1:0]  status,
	input  logic [fcm_pkg::BLK_W-1:0]   block,
	input  logic [fcm_pkg::ENTRY_W-1:0] link,
	input  logic                        is_end,
	output int                          err_count,
	output int                          pending
);
	import fcm_pkg::*;

	localparam int REPORT_LIMIT = 100;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [STAT_W-1:0]  status;
		logic [BLK_W-1:0]   block;
		logic [ENTRY_W-1:0] link;
		logic               is_end;
	} table_result_t;

	logic [ENTRY_W-1:0] shadow_table [BLOCK_COUNT];
	table_result_t      expected_words [$];
	int                 mismatches;

	// Put the shadow table back to its formatted contents
	function automatic void format_shadow();
		for (int i = 0; i < BLOCK_COUNT; i++)
			shadow_table[i] = ENT_FREE;
		for (int i = 0; i < RSVD_COUNT; i++)
			shadow_table[i] = ENT_RSVD;
		shadow_table[ROOT_BLOCK] = ENT_END;
	endfunction

	// Lowest free index, or BLOCK_COUNT when the table is full
	function automatic int lowest_free();
		for (int i = 0; i < BLOCK_COUNT; i++)
			if (shadow_table[i] == ENT_FREE)
				return i;
		return BLOCK_COUNT;
	endfunction

	// Follow a chain to its end marker; tail gets the end block
	function automatic logic [STAT_W-1:0] walk_chain(input int head, output int tail);
		int cur;
		int next_val;
		cur = head;
		tail = 0;
		if (cur >= BLOCK_COUNT)
			return ST_BAD;
		for (int n = 0; n < BLOCK_COUNT; n++) begin
			next_val = int'(shadow_table[cur]);
			if (next_val == int'(ENT_END)) begin
				tail = cur;
				return ST_OK;
			end
			if (next_val == int'(ENT_FREE) || next_val == int'(ENT_RSVD) ||
			    next_val >= BLOCK_COUNT)
				return ST_BAD;
			cur = next_val;
		end
		return ST_LONG;
	endfunction

	// Drop every entry of a checked chain except the end one; return the end block
	function automatic int release_to_tail(input int head);
		int cur;
		int nxt;
		cur = head;
		while (shadow_table[cur] != ENT_END) begin
			nxt = int'(shadow_table[cur]);
			shadow_table[cur] = ENT_FREE;
			cur = nxt;
		end
		return cur;
	endfunction

	// Apply one command word to the shadow table and build the result word it gives
	function automatic table_result_t predict_word(input logic [OP_W-1:0] cmd,
	                                               input logic [BLK_W-1:0] sb);
		table_result_t    r;
		int               head;
		int               tail;
		int               f;
		logic [STAT_W-1:0] st;
		r = '0;
		r.op = cmd;
		head = int'(sb);
		tail = 0;
		st = ST_OK;
		case (cmd)
		OP_FORMAT: format_shadow();
		OP_ALLOC: begin
			f = lowest_free();
			if (f >= BLOCK_COUNT) begin
				st = ST_FULL;
			end else begin
				shadow_table[f] = ENT_END;
				r.block = f[BLK_W-1:0];
			end
		end
		OP_FREE: begin
			st = walk_chain(head, tail);
			if (st == ST_OK) begin
				tail = release_to_tail(head);
				shadow_table[tail] = ENT_FREE;
			end
		end
		OP_KEEP: begin
			st = walk_chain(head, tail);
			if (st == ST_OK) begin
				tail = release_to_tail(head);
				r.block = tail[BLK_W-1:0];
			end
		end
		OP_EXTEND: begin
			// a chain fault wins over a full table
			st = walk_chain(head, tail);
			if (st == ST_OK) begin
				f = lowest_free();
				if (f >= BLOCK_COUNT) begin
					st = ST_FULL;
				end else begin
					shadow_table[tail] = f[ENTRY_W-1:0];
					shadow_table[f] = ENT_END;
					r.block = f[BLK_W-1:0];
				end
			end
		end
		OP_READ: begin
			if (head >= BLOCK_COUNT) begin
				st = ST_BAD;
			end else begin
				r.link = shadow_table[head];
				r.is_end = (shadow_table[head] == ENT_END);
			end
		end
		default: st = ST_BAD;
		endcase
		r.status = st;
		if (st != ST_OK) begin
			r.block = '0;
			r.link = '0;
			r.is_end = 1'b0;
		end
		return r;
	endfunction

	// Count and report one field that differs from its expectation
	task automatic check_field(input string name, input logic [ENTRY_W-1:0] want,
	                           input logic [ENTRY_W-1:0] got, input logic [OP_W-1:0] cmd);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch on op %0d: expected %0h, got %0h",
				         $time, name, cmd, want, got);
		end
	endtask

	// Compare each result word with the oldest expectation, then queue the new command
	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			format_shadow();
			expected_words.delete();
			mismatches = 0;
			err_count <= 0;
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result word with nothing expected: %s %0h %0h %0h %0b",
						         $time, "expected none, got", status, block, link,
						         is_end);
				end else begin
					want = expected_words.pop_front();
					check_field("status", ENTRY_W'(want.status), ENTRY_W'(status),
					            want.op);
					check_field("block", ENTRY_W'(want.block), ENTRY_W'(block), want.op);
					check_field("link", want.link, link, want.op);
					check_field("is_end", ENTRY_W'(want.is_end), ENTRY_W'(is_end),
					            want.op);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_words.push_back(predict_word(op, start_block));
			err_count <= mismatches;
			pending <= expected_words.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, command stimulus, watchdog and the final verdict.
module tb;
	import fcm_pkg::*;

	localparam int RANDOM_WORDS = 1425;
	localparam int IDLE_LIMIT   = 50000;
	localparam int DRAIN_CYCLES = 4 * BLOCK_COUNT_DEF;
	localparam int POOL_DEPTH   = 48;

	// op codes the block does not define
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [OP_W-1:0]    op;
	logic [BLK_W-1:0]   start_block;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [BLK_W-1:0]   block;
	logic [ENTRY_W-1:0] link;
	logic               is_end;

	int                 err_count;
	int                 pending;
	int                 idle_cycles;
	bit                 burst_mode;
	logic [BLK_W-1:0]   claimed_blocks [$];

	fat_chain_manager dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.start_block (start_block),
		.done        (done),
		.status      (status),
		.block       (block),
		.link        (link),
		.is_end      (is_end)
	);

	fcm_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.start_block (start_block),
		.done        (done),
		.status      (status),
		.block       (block),
		.link        (link),
		.is_end      (is_end),
		.err_count   (err_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none at all in burst stretches
	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// Chain heads come mostly from blocks the block has handed out lately
	function automatic logic [BLK_W-1:0] pick_block();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70 && claimed_blocks.size() > 0)
			return claimed_blocks[$urandom_range(0, claimed_blocks.size() - 1)];
		if (r < 85)
			return BLK_W'($urandom_range(0, 40));
		return BLK_W'($urandom_range(0, BLOCK_COUNT_DEF - 1));
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return OP_FORMAT;
		if (r < 20)
			return OP_ALLOC;
		if (r < 50)
			return OP_EXTEND;
		if (r < 62)
			return OP_FREE;
		if (r < 72)
			return OP_KEEP;
		if (r < 96)
			return OP_READ;
		if (r < 98)
			return OP_UNDEF_LO;
		return OP_UNDEF_HI;
	endfunction

	// Drop start for a random gap, with junk on the ignored command fields
	task automatic idle_gap();
		int n;
		n = pick_gap();
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			op <= OP_W'($urandom_range(0, 7));
			start_block <= BLK_W'($urandom_range(0, BLOCK_COUNT_DEF - 1));
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Present one command word and hold it until the block takes it
	task automatic send_word(input logic [OP_W-1:0] cmd, input logic [BLK_W-1:0] sb);
		@(negedge clk);
		op <= cmd;
		start_block <= sb;
		start <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		idle_gap();
	endtask

	// Remember blocks that came back as chain members
	always @(posedge clk) begin
		if (done === 1'b1 && status == ST_OK && block != '0) begin
			claimed_blocks.push_back(block);
			if (claimed_blocks.size() > POOL_DEPTH)
				void'(claimed_blocks.pop_front());
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("fat_chain_manager test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_FORMAT;
		start_block = '0;
		burst_mode = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reads of reserved, end and free entries, top index included
		send_word(OP_READ, 11'd0);
		send_word(OP_READ, BLK_W'(ROOT_BLOCK));
		send_word(OP_READ, 11'd2047);
		// build a short chain, trim it, then drop the pieces
		send_word(OP_ALLOC, 11'd1234);
		send_word(OP_ALLOC, 11'd0);
		send_word(OP_EXTEND, 11'd6);
		send_word(OP_EXTEND, 11'd6);
		send_word(OP_READ, 11'd6);
		send_word(OP_READ, 11'd8);
		send_word(OP_KEEP, 11'd6);
		send_word(OP_READ, 11'd6);
		send_word(OP_FREE, 11'd9);
		send_word(OP_FREE, 11'd7);
		// broken chains: reserved head, free head, dangling link
		send_word(OP_FREE, 11'd3);
		send_word(OP_FREE, 11'd6);
		send_word(OP_EXTEND, 11'd2047);
		send_word(OP_ALLOC, 11'd2047);
		send_word(OP_EXTEND, 11'd6);
		send_word(OP_FREE, 11'd7);
		send_word(OP_EXTEND, 11'd6);
		send_word(OP_KEEP, 11'd6);
		send_word(OP_UNDEF_LO, 11'd6);
		send_word(OP_UNDEF_HI, 11'd2047);
		send_word(OP_EXTEND, BLK_W'(ROOT_BLOCK));
		send_word(OP_FORMAT, 11'd1365);

		// random mix over live chains, stale blocks and noise
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 64 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			send_word(pick_op(), pick_block());
		end

		// drain: wait out every expected word, then watch for strays
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending == 0)
			$display("fat_chain_manager test passed");
		else
			$display("fat_chain_manager test failed");
		$finish;
	end

endmodule

>>> fat_chain_manager.f
hdl/fcm_pkg.sv
hdl/fcm_ram.sv
hdl/fcm_entry_eval.sv
hdl/fat_chain_manager.sv
tb/fcm_checker.sv
tb/tb.sv
